// ===== src/wrllp_pkg.sv =====
`timescale 1ns / 1ps
package wrllp_pkg;

   localparam int RAND_BITS = 31;
   localparam int CHOICE_BITS = 7;
   localparam int INDEX_FIELD_BITS = 4;
   localparam logic [CHOICE_BITS-1:0] CHOICES_RESET = 7'd1;

   typedef enum logic [0:0] {
      OP_UPDATE = 1'b0,
      OP_DRAW   = 1'b1
   } opcode_type;

   // controller to datapath
   typedef struct packed {
      logic write_entry;
      logic clear_scan;
      logic total_step;
      logic start_scale;
      logic clear_acc;
      logic pick_step;
      logic cross_mult;
      logic judge;
      logic end_selection;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_last;
      logic total_zero;
      logic scale_done;
      logic pick_hit;
      logic single_shot;
      logic selection_done;
   } status_type;

endpackage

// ===== src/wrllp_if.sv =====
`timescale 1ns / 1ps
interface wrllp_if #(
   parameter int WIDTH = 1
);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== src/weighted_random_least_load_pick_core.sv =====
`timescale 1ns / 1ps
// weighted random pick with least load per weight over several draws
// req channel: one beat is an update (opcode 0) or a draw (opcode 1)
// rsp channel: found and chosen_target, at most one beat per draw
// csr channel: writes the choices register, taken any cycle
// an update is written in its accept cycle; a draw runs through the accept
// cycle, a scan that totals the healthy weights, a check, the shift-add
// scaling multiplier, a walk of the running sum, and a cross multiplication
// and judge step that compares loads; after the last draw an emit step loads
// the rsp beat
// a selection ends with a rsp beat after the last draw, or after the first draw when
// the healthy weight is zero, one target is healthy or choices is at most 1
// the rsp beat sits in an output register; a stalled receiver holds the block
// at its next emit until the register frees, and a new beat is taken once it does
// reset clears the target table, the running selection and sets choices to 1
module weighted_random_least_load_pick_core
   import wrllp_pkg::*;
#(
   parameter int TARGETS = 16,
   parameter int WEIGHT_BITS = 16,
   parameter int LOAD_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   wrllp_if.sink   req,
   wrllp_if.sink   csr,
   wrllp_if.source rsp
);
   // req payload: opcode, target_index, weight, healthy, load_known, load, random_word
   typedef struct packed {
      logic [0:0]                  opcode;
      logic [INDEX_FIELD_BITS-1:0] target_index;
      logic [WEIGHT_BITS-1:0]      weight;
      logic                        healthy;
      logic                        load_known;
      logic [LOAD_BITS-1:0]        load;
      logic [RAND_BITS-1:0]        random_word;
   } req_beat_type;

   req_beat_type req_beat;
   cmd_type      cmd;
   status_type   status;
   logic [CHOICE_BITS-1:0] choices_ff, choices_in;
   logic         rsp_valid_ff, rsp_valid_in, rsp_load, rsp_free, res_found;
   logic [INDEX_FIELD_BITS-1:0] res_target;
   logic [INDEX_FIELD_BITS:0] rsp_data_ff, rsp_data_in;
   logic         req_ready_int;

   assign req_beat = req.payload;
   assign csr.ready = 1'b1;
   assign req.ready = req_ready_int;
   assign rsp_free = !rsp_valid_ff || rsp.ready;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = rsp_data_ff;

   always_comb begin
      choices_in = choices_ff;
      if (csr.valid) begin
         choices_in = csr.payload;
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in = {res_found, res_target};
      end
   end

   wrllp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req_ready_int),
      .req_op    (opcode_type'(req_beat.opcode)),
      .rsp_load  (rsp_load),
      .rsp_free  (rsp_free),
      .cmd       (cmd),
      .status    (status)
   );

   wrllp_datapath #(
      .TARGETS     (TARGETS),
      .WEIGHT_BITS (WEIGHT_BITS),
      .LOAD_BITS   (LOAD_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .choices       (choices_ff),
      .wr_index      (req_beat.target_index),
      .wr_weight     (req_beat.weight),
      .wr_healthy    (req_beat.healthy),
      .wr_load_known (req_beat.load_known),
      .wr_load       (req_beat.load),
      .random_word   (req_beat.random_word),
      .res_found     (res_found),
      .res_target    (res_target)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         choices_ff <= CHOICES_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         choices_ff <= choices_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> rsp_free)
      else $error("result loaded over a held beat");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> !req_ready_int)
      else $error("request taken while a result is produced");
   a_update_quick: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req_ready_int && req_beat.opcode == OP_UPDATE) |=> req_ready_int)
      else $error("update did not finish in one cycle");
endmodule

// ===== src/wrllp_datapath.sv =====
`timescale 1ns / 1ps
module wrllp_datapath
   import wrllp_pkg::*;
#(
   parameter int TARGETS = 16,
   parameter int WEIGHT_BITS = 16,
   parameter int LOAD_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  cmd_type                     cmd,
   output status_type                  status,
   input  logic [CHOICE_BITS-1:0]      choices,
   input  logic [INDEX_FIELD_BITS-1:0] wr_index,
   input  logic [WEIGHT_BITS-1:0]      wr_weight,
   input  logic                        wr_healthy,
   input  logic                        wr_load_known,
   input  logic [LOAD_BITS-1:0]        wr_load,
   input  logic [RAND_BITS-1:0]        random_word,
   output logic                        res_found,
   output logic [INDEX_FIELD_BITS-1:0] res_target
);
   localparam int IDX_BITS = (TARGETS > 1) ? $clog2(TARGETS) : 1;
   localparam int TOTAL_BITS = WEIGHT_BITS + IDX_BITS + 1;
   localparam int PROD_BITS = TOTAL_BITS + RAND_BITS;
   localparam int SCALE_BITS = TOTAL_BITS;
   localparam int CNT_BITS = IDX_BITS + 1;
   localparam int HC_BITS = IDX_BITS + 2;

   logic [WEIGHT_BITS-1:0] weight_ff [TARGETS];
   logic [WEIGHT_BITS-1:0] weight_in [TARGETS];
   logic [LOAD_BITS-1:0]   load_ff [TARGETS];
   logic [LOAD_BITS-1:0]   load_in [TARGETS];
   logic [TARGETS-1:0]     healthy_ff, healthy_in, known_ff, known_in;

   logic [CNT_BITS-1:0]    scan_ff, scan_in;
   logic [TOTAL_BITS-1:0]  total_ff, total_in, acc_ff, acc_in;
   logic [HC_BITS-1:0]     hcount_ff, hcount_in;
   logic [PROD_BITS-1:0]   prod_ff, prod_in, mcand_ff, mcand_in;
   logic [RAND_BITS-1:0]   mplier_ff, mplier_in;
   logic [4:0]             mstep_ff, mstep_in;
   logic [IDX_BITS-1:0]    pick_ff, pick_in;
   logic [CHOICE_BITS-1:0] draws_ff, draws_in;
   logic [IDX_BITS-1:0]    best_index_ff, best_index_in;
   logic                   best_valid_ff, best_valid_in, best_has_load_ff, best_has_load_in;
   logic [LOAD_BITS-1:0]   best_load_ff, best_load_in;
   logic [WEIGHT_BITS-1:0] best_weight_ff, best_weight_in;
   logic [LOAD_BITS+WEIGHT_BITS-1:0] lhs_ff, lhs_in, rhs_ff, rhs_in;

   logic [IDX_BITS-1:0]    scan_idx;
   logic [SCALE_BITS-1:0]  scaled;
   logic [TOTAL_BITS-1:0]  acc_next;
   logic                   wr_ok;
   logic [CHOICE_BITS-1:0] draws_plus;
   logic [INDEX_FIELD_BITS+IDX_BITS-1:0] best_wide;

   assign scan_idx = scan_ff[IDX_BITS-1:0];
   assign scaled = prod_ff[RAND_BITS +: SCALE_BITS];
   assign acc_next = acc_ff + TOTAL_BITS'(weight_ff[scan_idx]);
   assign wr_ok = ({1'b0, wr_index} < (INDEX_FIELD_BITS+1)'(TARGETS));
   assign draws_plus = draws_ff + 1'b1;
   assign best_wide = (INDEX_FIELD_BITS+IDX_BITS)'(best_index_ff);

   always_comb begin
      weight_in = weight_ff;
      load_in = load_ff;
      healthy_in = healthy_ff;
      known_in = known_ff;
      if (cmd.write_entry && wr_ok) begin
         weight_in[wr_index[IDX_BITS-1:0]] = wr_weight;
         load_in[wr_index[IDX_BITS-1:0]] = wr_load;
         healthy_in[wr_index[IDX_BITS-1:0]] = wr_healthy;
         known_in[wr_index[IDX_BITS-1:0]] = wr_load_known;
      end
   end

   always_comb begin
      scan_in = scan_ff;
      total_in = total_ff;
      hcount_in = hcount_ff;
      acc_in = acc_ff;
      pick_in = pick_ff;
      if (cmd.clear_scan) begin
         scan_in = '0;
         total_in = '0;
         hcount_in = '0;
      end else if (cmd.total_step) begin
         scan_in = scan_ff + 1'b1;
         if (healthy_ff[scan_idx]) begin
            total_in = total_ff + TOTAL_BITS'(weight_ff[scan_idx]);
            hcount_in = hcount_ff + 1'b1;
         end
      end
      if (cmd.clear_acc) begin
         scan_in = '0;
         acc_in = '0;
         pick_in = '0;
      end else if (cmd.pick_step) begin
         scan_in = scan_ff + 1'b1;
         if (healthy_ff[scan_idx]) begin
            acc_in = acc_next;
         end
         pick_in = scan_idx;
      end
   end

   assign status.scan_last = (scan_ff == CNT_BITS'(TARGETS - 1));
   assign status.total_zero = (total_ff == '0);
   assign status.pick_hit = healthy_ff[scan_idx] && (scaled < acc_next);
   assign status.single_shot = (hcount_ff <= HC_BITS'(1)) || (choices <= CHOICE_BITS'(1));
   assign status.selection_done = (draws_plus >= choices);
   assign status.scale_done = (mstep_ff == 5'd0);

   // shift-add multiply, two bits a cycle
   // random word is captured with the draw beat
   always_comb begin
      prod_in = prod_ff;
      mcand_in = mcand_ff;
      mplier_in = mplier_ff;
      mstep_in = mstep_ff;
      if (cmd.clear_scan) begin
         mplier_in = random_word;
      end else if (cmd.start_scale) begin
         prod_in = '0;
         mcand_in = PROD_BITS'(total_ff);
         mstep_in = 5'd16;
      end else if (mstep_ff != 5'd0) begin
         prod_in = prod_ff
            + (mplier_ff[0] ? mcand_ff : '0)
            + (mplier_ff[1] ? {mcand_ff[PROD_BITS-2:0], 1'b0} : '0);
         mcand_in = {mcand_ff[PROD_BITS-3:0], 2'b00};
         mplier_in = mplier_ff >> 2;
         mstep_in = mstep_ff - 1'b1;
      end
   end

   always_comb begin
      lhs_in = lhs_ff;
      rhs_in = rhs_ff;
      if (cmd.cross_mult) begin
         lhs_in = load_ff[pick_ff] * best_weight_ff;
         rhs_in = best_load_ff * weight_ff[pick_ff];
      end
   end

   always_comb begin
      best_index_in = best_index_ff;
      best_valid_in = best_valid_ff;
      best_has_load_in = best_has_load_ff;
      best_load_in = best_load_ff;
      best_weight_in = best_weight_ff;
      draws_in = draws_ff;
      if (cmd.end_selection) begin
         best_index_in = '0;
         best_valid_in = 1'b0;
         best_has_load_in = 1'b0;
         best_load_in = '0;
         best_weight_in = '0;
         draws_in = '0;
      end else if (cmd.judge) begin
         draws_in = draws_plus;
         if (!best_valid_ff || pick_ff != best_index_ff) begin
            if (known_ff[pick_ff]) begin
               if (!best_valid_ff || !best_has_load_ff || lhs_ff < rhs_ff) begin
                  best_index_in = pick_ff;
                  best_valid_in = 1'b1;
                  best_has_load_in = 1'b1;
                  best_load_in = load_ff[pick_ff];
                  best_weight_in = weight_ff[pick_ff];
               end
            end else if (!best_valid_ff) begin
               best_index_in = pick_ff;
               best_valid_in = 1'b1;
               best_has_load_in = 1'b0;
               best_load_in = '0;
               best_weight_in = weight_ff[pick_ff];
            end
         end
      end
   end

   always_comb begin
      res_found = !status.total_zero;
      res_target = INDEX_FIELD_BITS'((INDEX_FIELD_BITS+IDX_BITS)'(pick_ff));
      if (status.total_zero) begin
         res_target = '0;
      end else if (!status.single_shot) begin
         res_target = INDEX_FIELD_BITS'(best_wide);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         healthy_ff <= '0;
         known_ff <= '0;
         for (int i = 0; i < TARGETS; i++) begin
            weight_ff[i] <= '0;
            load_ff[i] <= '0;
         end
         best_index_ff <= '0;
         best_valid_ff <= 1'b0;
         best_has_load_ff <= 1'b0;
         best_load_ff <= '0;
         best_weight_ff <= '0;
         draws_ff <= '0;
         mstep_ff <= '0;
         scan_ff <= '0;
      end else begin
         healthy_ff <= healthy_in;
         known_ff <= known_in;
         weight_ff <= weight_in;
         load_ff <= load_in;
         best_index_ff <= best_index_in;
         best_valid_ff <= best_valid_in;
         best_has_load_ff <= best_has_load_in;
         best_load_ff <= best_load_in;
         best_weight_ff <= best_weight_in;
         draws_ff <= draws_in;
         mstep_ff <= mstep_in;
         scan_ff <= scan_in;
      end
   end

   always_ff @(posedge clock) begin
      total_ff <= total_in;
      hcount_ff <= hcount_in;
      acc_ff <= acc_in;
      pick_ff <= pick_in;
      prod_ff <= prod_in;
      mcand_ff <= mcand_in;
      mplier_ff <= mplier_in;
      lhs_ff <= lhs_in;
      rhs_ff <= rhs_in;
   end
endmodule

// ===== src/wrllp_ctrl.sv =====
`timescale 1ns / 1ps
module wrllp_ctrl
   import wrllp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  opcode_type req_op,
   output logic       rsp_load,
   input  logic       rsp_free,
   output cmd_type    cmd,
   input  status_type status
);
   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_TOTAL = 8'b0000_0010,
      S_CHECK = 8'b0000_0100,
      S_SCALE = 8'b0000_1000,
      S_PICK  = 8'b0001_0000,
      S_CROSS = 8'b0010_0000,
      S_JUDGE = 8'b0100_0000,
      S_EMIT  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      rsp_load = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_op == OP_UPDATE) begin
                  cmd.write_entry = 1'b1;
               end else begin
                  cmd.clear_scan = 1'b1;
                  state_in = S_TOTAL;
               end
            end
         end
         S_TOTAL: begin
            cmd.total_step = 1'b1;
            if (status.scan_last) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.total_zero) begin
               state_in = S_EMIT;
            end else begin
               cmd.start_scale = 1'b1;
               state_in = S_SCALE;
            end
         end
         S_SCALE: begin
            cmd.clear_acc = status.scale_done;
            if (status.scale_done) begin
               state_in = S_PICK;
            end
         end
         S_PICK: begin
            cmd.pick_step = 1'b1;
            if (status.pick_hit || status.scan_last) begin
               if (status.single_shot) begin
                  state_in = S_EMIT;
               end else begin
                  state_in = S_CROSS;
               end
            end
         end
         S_CROSS: begin
            cmd.cross_mult = 1'b1;
            state_in = S_JUDGE;
         end
         S_JUDGE: begin
            if (status.selection_done) begin
               cmd.judge = 1'b1;
               state_in = S_EMIT;
            end else begin
               cmd.judge = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_EMIT: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
               cmd.end_selection = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
